[design/wat_pkg.sv]
package wat_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_FIELD_W = 4;
    localparam int CMP_W = (CNT_W > IDX_FIELD_W) ? CNT_W : IDX_FIELD_W;

    localparam logic [2:0] DAYS_PER_WEEK = 3'd7;
    localparam logic [2:0] DAY_NONE = 3'd7;   // never rung: matches no weekday

    typedef enum logic [1:0] {
        OP_ADD       = 2'd0,
        OP_REM_MATCH = 2'd1,
        OP_REM_IDX   = 2'd2,
        OP_CHECK     = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] mask;
        logic       rep;
        logic [2:0] last_day;
    } alarm_t;

    typedef struct packed {
        logic load;    // take the shared entry bus
        logic shift;   // take the right neighbor
    } cell_ctl_t;

    typedef struct packed {
        logic   drop;
        logic   fire;
        alarm_t entry;
    } head_res_t;

endpackage

[design/wat_cell.sv]
module wat_cell
    import wat_pkg::*;
(
    input  logic      aclk,
    input  cell_ctl_t ctl,
    input  alarm_t    nbr_in,
    input  alarm_t    new_in,
    output alarm_t    entry
);

    alarm_t entry_reg;

    // load wins: an insert at the queue tail replaces the shifted value
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            entry_reg <= new_in;
        end else if (ctl.shift) begin
            entry_reg <= nbr_in;
        end
    end

    assign entry = entry_reg;

endmodule

[design/wat_head.sv]
module wat_head
    import wat_pkg::*;
(
    input  op_t              op,
    input  alarm_t           key,
    input  logic [IDX_FIELD_W-1:0] idx,
    input  logic [2:0]       day,
    input  logic [CNT_W-1:0] pos,
    input  logic             already_fired,
    input  alarm_t           head,
    output head_res_t        res
);

    logic [6:0] mask_sh;
    logic       same_alarm;
    logic       due;

    assign mask_sh = head.mask >> day;
    assign same_alarm = (head.hour == key.hour) && (head.minute == key.minute) &&
                        (head.mask == key.mask) && (head.rep == key.rep);
    assign due = !already_fired && (head.hour == key.hour) &&
                 (head.minute == key.minute) && (head.last_day != day) &&
                 (day < DAYS_PER_WEEK) && mask_sh[0];

    always_comb begin
        res.drop  = 1'b0;
        res.fire  = 1'b0;
        res.entry = head;
        unique case (op)
            OP_REM_MATCH: res.drop = same_alarm;
            OP_REM_IDX:   res.drop = (CMP_W'(pos) == CMP_W'(idx));
            OP_CHECK: begin
                if (due) begin
                    res.fire = 1'b1;
                    res.entry.last_day = day;
                    res.drop = !head.rep;
                end
            end
            default: res.drop = 1'b0;
        endcase
    end

endmodule

[design/weekday_alarm_table.sv]
// Channel  Dir  Fields (lowest bit up)
// -------  ---  -----------------------------------------------------------
// s_       in   tuser: opcode[1:0]
//               tdata: alarm_hour[4:0] alarm_minute[10:5] day_mask[17:11]
//                      repeat_req[18] entry_index[22:19] current_day[25:23]
// m_       out  tdata: status[1:0] alarm_fired[2] removed_count[7:3]
//                      entry_count[12:8]
//
// One beat in, one beat out; a new beat is accepted only once the result of
// the last is registered. The table is a queue in a row of cells; for a
// check or an accepted remove every stored alarm passes the head once, one
// per cycle.
// aresetn is synchronous, active low; it empties the table (count only).
// A waiting result does not block the next op; the finish step waits for
// the output register to free up when m_tready is held low.
module weekday_alarm_table
    import wat_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // opcode
    input  logic [31:0] s_tdata,    // alarm_hour, alarm_minute, day_mask, repeat_req,
                                    // entry_index, current_day, zero fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // status, alarm_fired, removed_count,
                                    // entry_count, zero fill
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FIN
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;     // live queue length
    logic [CNT_W-1:0]       rem_reg;       // entries still to pass the head
    logic [CNT_W-1:0]       pos_reg;       // original index of the head entry
    logic [CNT_W-1:0]       removed_reg;
    logic                   fired_reg;
    status_t                status_reg;
    op_t                    op_reg;
    alarm_t                 key_reg;
    logic [IDX_FIELD_W-1:0] idx_reg;
    logic [2:0]             day_reg;
    logic                   m_tvalid_reg;
    logic [15:0]            m_tdata_reg;

    // input beat fields
    op_t                    in_op;
    alarm_t                 in_key;
    logic [IDX_FIELD_W-1:0] in_idx;
    logic [2:0]             in_day;

    assign in_op           = op_t'(s_tuser);
    assign in_key.hour     = s_tdata[4:0];
    assign in_key.minute   = s_tdata[10:5];
    assign in_key.mask     = s_tdata[17:11];
    assign in_key.rep      = s_tdata[18];
    assign in_key.last_day = DAY_NONE;
    assign in_idx          = s_tdata[22:19];
    assign in_day          = s_tdata[25:23];

    // cell row: cell 0 is the queue head
    alarm_t           cell_q [MAX_ENTRIES];
    cell_ctl_t        cell_ctl [MAX_ENTRIES];
    alarm_t           new_bus;
    head_res_t        head_res;
    logic             step;
    logic             add_wr;
    logic [CNT_W-1:0] tail_pos;

    // a step pops the head; a kept head is pushed back at the tail
    assign step     = (state_reg == S_RUN) && (op_reg != OP_ADD) && (rem_reg != '0);
    assign add_wr   = (state_reg == S_RUN) && (op_reg == OP_ADD) && (status_reg == STAT_OK);
    assign tail_pos = count_reg - CNT_W'(1);
    assign new_bus  = add_wr ? key_reg : head_res.entry;

    wat_head u_head (
        .op            (op_reg),
        .key           (key_reg),
        .idx           (idx_reg),
        .day           (day_reg),
        .pos           (pos_reg),
        .already_fired (fired_reg),
        .head          (cell_q[0]),
        .res           (head_res)
    );

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        alarm_t nbr;
        if (i == MAX_ENTRIES - 1) begin : g_last
            assign nbr = cell_q[0];
        end else begin : g_mid
            assign nbr = cell_q[i+1];
        end

        assign cell_ctl[i].shift = step;
        assign cell_ctl[i].load  = (add_wr && (count_reg == CNT_W'(i))) ||
                                   (step && !head_res.drop && (tail_pos == CNT_W'(i)));

        wat_cell u_cell (
            .aclk   (aclk),
            .ctl    (cell_ctl[i]),
            .nbr_in (nbr),
            .new_in (new_bus),
            .entry  (cell_q[i])
        );
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            rem_reg      <= '0;
            fired_reg    <= 1'b0;
            removed_reg  <= '0;
            pos_reg      <= '0;
            status_reg   <= STAT_OK;
            op_reg       <= OP_ADD;
        end else begin
            // the finish step handles its own output handover
            if (m_tvalid_reg && m_tready && (state_reg != S_FIN)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        op_reg      <= in_op;
                        key_reg     <= in_key;
                        idx_reg     <= in_idx;
                        day_reg     <= in_day;
                        pos_reg     <= '0;
                        removed_reg <= '0;
                        fired_reg   <= 1'b0;
                        if (in_op == OP_ADD) begin
                            rem_reg    <= '0;
                            status_reg <= (count_reg >= CNT_W'(MAX_ENTRIES)) ?
                                          STAT_FULL : STAT_OK;
                        end else if (in_op == OP_REM_IDX &&
                                     CMP_W'(in_idx) >= CMP_W'(count_reg)) begin
                            rem_reg    <= '0;
                            status_reg <= STAT_RANGE;
                        end else begin
                            rem_reg    <= count_reg;
                            status_reg <= STAT_OK;
                        end
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (op_reg == OP_ADD) begin
                        if (add_wr) begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                        state_reg <= S_FIN;
                    end else if (rem_reg == '0) begin
                        state_reg <= S_FIN;
                    end else begin
                        rem_reg <= rem_reg - CNT_W'(1);
                        pos_reg <= pos_reg + CNT_W'(1);
                        if (head_res.drop) begin
                            count_reg   <= count_reg - CNT_W'(1);
                            removed_reg <= removed_reg + CNT_W'(1);
                        end
                        if (head_res.fire) begin
                            fired_reg <= 1'b1;
                        end
                    end
                end
                S_FIN: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {3'b000, 5'(count_reg), 5'(removed_reg),
                                         fired_reg, status_reg};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // queue length never exceeds the row
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    // each scan step retires exactly one entry from the pass
    a_scan_step: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> (rem_reg == $past(rem_reg) - CNT_W'(1)))
        else $error("scan counter did not advance");

    // a refused op touches nothing
    a_refused_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) && (m_tdata_reg[1:0] != STAT_OK) |->
            (m_tdata_reg[7:2] == 6'd0))
        else $error("refused op reported removal or fire");

    // only remove-matching may drop more than one entry
    a_single_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) && (op_reg != OP_REM_MATCH) |->
            (m_tdata_reg[7:3] <= 5'd1))
        else $error("more than one entry removed");

endmodule

[verif/weekday_alarm_table_tb.sv]
`timescale 1ns / 100ps

module weekday_alarm_table_tb;
    import wat_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;  // watchdog limit, well above the slowest legal run
    localparam int DRAIN_CYCLES = 64;      // idle tail after the last result, with slack for output stalls
    localparam int RANDOM_BEATS = 417;     // per idle phase, three phases

    // Result beat as it sits in m_tdata[12:0], lowest field last in the list.
    typedef struct packed {
        logic [4:0] entry_count;
        logic [4:0] removed_count;
        logic       alarm_fired;
        status_t    status;
    } beat_result_t;

    // Tracks the alarm table alongside the DUT and queues one expected
    // result per accepted request beat.
    class alarm_table_scoreboard;
        alarm_t       slots[MAX_ENTRIES];
        int           n_alarms;
        beat_result_t expected_results[$];
        int           mismatch_count;

        function new();
            n_alarms = 0;
            mismatch_count = 0;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // Compact the table: everything above pos moves down one slot.
        function void drop_slot(int pos);
            for (int k = pos; k + 1 < n_alarms; k++) begin
                slots[k] = slots[k + 1];
            end
            n_alarms--;
        endfunction

        function void note_request(logic [1:0] op_bits, logic [31:0] data);
            op_t          op;
            logic [4:0]   hr;
            logic [5:0]   mn;
            logic [6:0]   msk;
            logic         rp;
            logic [3:0]   ix;
            logic [2:0]   dy;
            beat_result_t r;
            int           i;
            bit           done;
            op  = op_t'(op_bits);
            hr  = data[4:0];
            mn  = data[10:5];
            msk = data[17:11];
            rp  = data[18];
            ix  = data[22:19];
            dy  = data[25:23];
            r   = '0;
            r.status = STAT_OK;
            done = 1'b0;
            case (op)
                OP_ADD: begin
                    if (n_alarms >= MAX_ENTRIES) begin
                        r.status = STAT_FULL;
                    end else begin
                        slots[n_alarms] = '{hour: hr, minute: mn, mask: msk, rep: rp,
                                            last_day: DAY_NONE};
                        n_alarms++;
                    end
                end
                OP_REM_MATCH: begin
                    // last rung day is not part of the match
                    i = 0;
                    while (i < n_alarms) begin
                        if (slots[i].hour == hr && slots[i].minute == mn &&
                            slots[i].mask == msk && slots[i].rep == rp) begin
                            drop_slot(i);
                            r.removed_count = r.removed_count + 5'd1;
                        end else begin
                            i++;
                        end
                    end
                end
                OP_REM_IDX: begin
                    if (int'(ix) >= n_alarms) begin
                        r.status = STAT_RANGE;
                    end else begin
                        drop_slot(int'(ix));
                        r.removed_count = 5'd1;
                    end
                end
                default: begin  // OP_CHECK: first due entry not yet rung today
                    for (i = 0; i < n_alarms && !done; i++) begin
                        if (slots[i].hour == hr && slots[i].minute == mn &&
                            slots[i].last_day != dy && dy < DAYS_PER_WEEK &&
                            ((slots[i].mask >> dy) & 7'd1) != 7'd0) begin
                            slots[i].last_day = dy;
                            r.alarm_fired = 1'b1;
                            if (!slots[i].rep) begin
                                drop_slot(i);
                                r.removed_count = 5'd1;
                            end
                            done = 1'b1;
                        end
                    end
                end
            endcase
            r.entry_count = 5'(n_alarms);
            expected_results.push_back(r);
        endfunction

        function void check_response(logic [15:0] data);
            beat_result_t got;
            beat_result_t want;
            got = data[12:0];
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] result beat with nothing expected: tdata=%h", $realtime, data);
                return;
            end
            want = expected_results.pop_front();
            if (got.status != want.status || got.alarm_fired != want.alarm_fired ||
                got.removed_count != want.removed_count ||
                got.entry_count != want.entry_count) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("[%0t] mismatch: exp st=%0d fired=%0d rem=%0d cnt=%0d, got st=%0d fired=%0d rem=%0d cnt=%0d",
                             $realtime, want.status, want.alarm_fired, want.removed_count,
                             want.entry_count, got.status, got.alarm_fired,
                             got.removed_count, got.entry_count);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [1:0]  s_tuser  = '0;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    alarm_table_scoreboard sb = new();

    int  send_idle_pct = 17;
    int  recv_idle_pct = 86;
    int  cycle_count   = 0;
    bit  filling       = 1'b1;   // random mix leans toward adds while set

    always #6 aclk = ~aclk;

    weekday_alarm_table i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** weekday_alarm_table: FAILED **");
            $finish;
        end
    end

    // Result side: check the beat taken at this edge, then pick next ready.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_response(m_tdata);
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Present one request beat and hold it until accepted. Valid only drops
    // when a gap is taken, so back-to-back beats keep it high.
    task automatic send_op(op_t op, logic [4:0] hr, logic [5:0] mn, logic [6:0] msk,
                           logic rp, logic [3:0] ix, logic [2:0] dy);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, dy, ix, rp, msk, mn, hr};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_request(s_tuser, s_tdata);
    endtask

    // Random beat. Times come mostly from a tiny pool, and matches/checks
    // often reuse a stored entry, so removals and firings actually happen.
    task automatic send_random();
        op_t         op;
        logic [4:0]  hr;
        logic [5:0]  mn;
        logic [6:0]  msk;
        logic        rp;
        logic [3:0]  ix;
        logic [2:0]  dy;
        int          w;
        int          pick;
        if ($urandom_range(59) == 0) filling = !filling;
        w = $urandom_range(99);
        if (filling)
            op = (w < 55) ? OP_ADD : (w < 65) ? OP_REM_MATCH : (w < 75) ? OP_REM_IDX : OP_CHECK;
        else
            op = (w < 15) ? OP_ADD : (w < 40) ? OP_REM_MATCH : (w < 70) ? OP_REM_IDX : OP_CHECK;
        hr  = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(2));
        mn  = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(2));
        case ($urandom_range(3))
            0:       msk = 7'h7F;                      // every day
            1:       msk = 7'(1 << $urandom_range(6)); // single day
            default: msk = 7'($urandom_range(127));
        endcase
        rp  = 1'($urandom_range(1));
        dy  = 3'($urandom_range(7));
        if (sb.n_alarms > 0 && $urandom_range(3) != 0)
            ix = 4'($urandom_range(sb.n_alarms - 1));
        else
            ix = 4'($urandom_range(15));
        if (sb.n_alarms > 0 && $urandom_range(9) < 7) begin
            pick = $urandom_range(sb.n_alarms - 1);
            if (op == OP_REM_MATCH) begin
                hr  = sb.slots[pick].hour;
                mn  = sb.slots[pick].minute;
                msk = sb.slots[pick].mask;
                rp  = sb.slots[pick].rep;
            end else if (op == OP_CHECK) begin
                hr = sb.slots[pick].hour;
                mn = sb.slots[pick].minute;
            end
        end
        send_op(op, hr, mn, msk, rp, ix, dy);
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty-table ops first.
        send_op(OP_CHECK,     5'd0,  6'd0,  7'h7F, 1'b1, 4'd0,  3'd0);  // nothing stored
        send_op(OP_REM_IDX,   5'd0,  6'd0,  7'h00, 1'b0, 4'd0,  3'd0);  // index out of range
        send_op(OP_REM_MATCH, 5'd0,  6'd0,  7'h00, 1'b0, 4'd0,  3'd0);  // no match, still ok
        // Field extremes; hour/minute beyond a real clock are stored as given.
        send_op(OP_ADD,       5'd31, 6'd63, 7'h7F, 1'b1, 4'd15, 3'd7);
        send_op(OP_ADD,       5'd0,  6'd0,  7'h00, 1'b0, 4'd0,  3'd0);
        send_op(OP_CHECK,     5'd31, 6'd63, 7'h00, 1'b0, 4'd0,  3'd0);  // repeating fires
        send_op(OP_CHECK,     5'd31, 6'd63, 7'h00, 1'b0, 4'd0,  3'd0);  // already rang today
        send_op(OP_CHECK,     5'd31, 6'd63, 7'h00, 1'b0, 4'd0,  3'd7);  // day 7: never due
        send_op(OP_CHECK,     5'd31, 6'd63, 7'h00, 1'b0, 4'd0,  3'd6);  // day 6 fires again
        // One-shot fires and is removed.
        send_op(OP_ADD,       5'd5,  6'd30, 7'h01, 1'b0, 4'd0,  3'd0);
        send_op(OP_CHECK,     5'd5,  6'd30, 7'h00, 1'b0, 4'd0,  3'd0);
        // Mask-0 entry never fires; it goes by exact match.
        send_op(OP_REM_MATCH, 5'd0,  6'd0,  7'h00, 1'b0, 4'd0,  3'd0);
        // Two identical entries leave together, after one has rung.
        send_op(OP_ADD,       5'd7,  6'd15, 7'h55, 1'b1, 4'd0,  3'd0);
        send_op(OP_ADD,       5'd7,  6'd15, 7'h55, 1'b1, 4'd0,  3'd0);
        send_op(OP_CHECK,     5'd7,  6'd15, 7'h00, 1'b0, 4'd0,  3'd2);  // first copy rings
        send_op(OP_REM_MATCH, 5'd7,  6'd15, 7'h55, 1'b1, 4'd9,  3'd0);
        send_op(OP_REM_IDX,   5'd0,  6'd0,  7'h00, 1'b0, 4'd15, 3'd0);  // out of range
        send_op(OP_REM_IDX,   5'd0,  6'd0,  7'h00, 1'b0, 4'd0,  3'd0);  // empties table

        // Random: eager sender / busy receiver, then swapped, then full rate.
        // Table-full refusals come from the add-heavy stretches.
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 17; recv_idle_pct = 86; end
                1:       begin send_idle_pct = 86; recv_idle_pct = 17; end
                default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            endcase
            repeat (RANDOM_BEATS) send_random();
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatch_count == 0 && sb.pending() == 0) begin
            $display("** weekday_alarm_table: PASSED **");
        end else begin
            $display("** weekday_alarm_table: FAILED **");
        end
        $finish;
    end

endmodule

[weekday_alarm_table.f]
design/wat_pkg.sv
design/wat_cell.sv
design/wat_head.sv
design/weekday_alarm_table.sv
verif/weekday_alarm_table_tb.sv
